// ===== hw/rtl/lom_pkg.sv =====
// Shared types and codes for the limit order matching core.
`timescale 1ns / 1ps
`default_nettype none
package lom_pkg;
   localparam int unsigned OpW = 2;
   localparam int unsigned QtyW = 24;
   localparam int unsigned PriceW = 32;
   localparam int unsigned IdW = 32;
   localparam int unsigned KindW = 3;

   typedef enum logic [OpW-1:0] {
      OP_BUY = 2'd0,
      OP_SELL = 2'd1,
      OP_CANCEL = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [KindW-1:0] {
      K_FILL = 3'd0,
      K_RESTED = 3'd1,
      K_FULL_FILL = 3'd2,
      K_CANCELLED = 3'd3,
      K_UNKNOWN = 3'd4,
      K_BOOK_FULL = 3'd5,
      K_REJECTED = 3'd6
   } kind_type;

   typedef struct packed {
      logic [OpW-1:0] operation;
      logic [QtyW-1:0] quantity;
      logic [PriceW-1:0] limit_price;
      logic [IdW-1:0] cancel_id;
   } req_type;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [IdW-1:0] order_id;
      logic [PriceW-1:0] trade_price;
      logic [QtyW-1:0] trade_quantity;
      logic [QtyW-1:0] remaining;
      logic last;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/lom_if.sv =====
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps
`default_nettype none
interface lom_req_if;
   import lom_pkg::*;
   logic valid;
   logic ready;
   logic [OpW-1:0] operation;
   logic [QtyW-1:0] quantity;
   logic [PriceW-1:0] limit_price;
   logic [IdW-1:0] cancel_id;
   modport source (output valid, operation, quantity, limit_price, cancel_id, input ready);
   modport sink (input valid, operation, quantity, limit_price, cancel_id, output ready);
endinterface

interface lom_rsp_if;
   import lom_pkg::*;
   logic valid;
   logic ready;
   logic [KindW-1:0] kind;
   logic [IdW-1:0] order_id;
   logic [PriceW-1:0] trade_price;
   logic [QtyW-1:0] trade_quantity;
   logic [QtyW-1:0] remaining;
   logic last;
   modport source (output valid, kind, order_id, trade_price, trade_quantity, remaining,
                   last, input ready);
   modport sink (input valid, kind, order_id, trade_price, trade_quantity, remaining, last,
                 output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/limit_order_matching_core.sv =====
// Top level of the limit order matching core: book storage and scan sequencer.
// A cancel searches the slots for its id, and an invalid request is rejected on the next cycle;
// a new order scans all slots for the best cross before each fill, then searches for a free
// slot unless it filled in full. Response stalls hold the sequencer.
// Throughput: one word at a time; the shared compare unit walks one slot per cycle.
// Reset (synchronous, active high) clears all slot valid bits and the id counter.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_matching_core #(
   parameter int unsigned MAX_RESTING = 32
) (
   input wire logic clock,
   input wire logic reset,
   lom_req_if.sink req,
   lom_rsp_if.source rsp
);
   import lom_pkg::*;

   localparam int unsigned SW = $clog2(MAX_RESTING);
   localparam int unsigned CW = $clog2(MAX_RESTING + 1);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_FILL = 5'b00100,
      S_EMIT = 5'b01000,
      S_FREE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [MAX_RESTING-1:0] valid_ff, valid_in;
   logic [MAX_RESTING-1:0] sell_ff;
   logic [PriceW-1:0] price_ff [MAX_RESTING];
   logic [QtyW-1:0] qty_ff [MAX_RESTING];
   logic [IdW-1:0] oid_ff [MAX_RESTING];
   logic [IdW-1:0] next_id_ff, next_id_in;

   // Working copy of the current request.
   logic [OpW-1:0] op_ff, op_in;
   logic [QtyW-1:0] rem_ff, rem_in;
   logic [PriceW-1:0] lim_ff, lim_in;
   logic [IdW-1:0] cid_ff, cid_in;
   logic [IdW-1:0] id_ff, id_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] nfill_ff, nfill_in;
   logic found_ff, found_in;
   logic [SW-1:0] best_ff, best_in;
   logic [PriceW-1:0] bprice_ff, bprice_in;
   logic [IdW-1:0] bage_ff, bage_in;
   logic [QtyW-1:0] fill_ff, fill_in;
   logic done_ff, done_in;

   logic ovalid_ff, ovalid_in;
   rsp_type out_ff, out_in;

   logic wr_en;
   logic [SW-1:0] wr_idx;
   logic [QtyW-1:0] wr_qty;
   logic wr_full;

   logic [SW-1:0] cur;
   logic cand, better;
   logic [PriceW-1:0] cp;
   logic [IdW-1:0] cage;
   logic is_sell;

   assign cur = idx_ff[SW-1:0];
   assign is_sell = (op_ff == OP_SELL);
   assign cp = price_ff[cur];
   assign cage = id_ff - oid_ff[cur];

   // Shared compare unit: judges one slot per cycle against the best so far.
   always_comb begin
      cand = valid_ff[cur] && (sell_ff[cur] != is_sell) &&
             (is_sell ? (cp >= lim_ff) : (cp <= lim_ff));
      if (!found_ff) begin
         better = 1'b1;
      end else if (cp != bprice_ff) begin
         better = is_sell ? (cp > bprice_ff) : (cp < bprice_ff);
      end else begin
         better = cage > bage_ff;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.kind = out_ff.kind;
   assign rsp.order_id = out_ff.order_id;
   assign rsp.trade_price = out_ff.trade_price;
   assign rsp.trade_quantity = out_ff.trade_quantity;
   assign rsp.remaining = out_ff.remaining;
   assign rsp.last = out_ff.last;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      next_id_in = next_id_ff;
      op_in = op_ff;
      rem_in = rem_ff;
      lim_in = lim_ff;
      cid_in = cid_ff;
      id_in = id_ff;
      idx_in = idx_ff;
      nfill_in = nfill_ff;
      found_in = found_ff;
      best_in = best_ff;
      bprice_in = bprice_ff;
      bage_in = bage_ff;
      fill_in = fill_ff;
      done_in = done_ff;
      ovalid_in = ovalid_ff;
      out_in = out_ff;
      wr_en = 1'b0;
      wr_full = 1'b0;
      wr_idx = best_ff;
      wr_qty = '0;
      if (ovalid_ff && rsp.ready) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.operation;
               rem_in = req.quantity;
               lim_in = req.limit_price;
               cid_in = req.cancel_id;
               id_in = next_id_ff;
               idx_in = '0;
               nfill_in = '0;
               found_in = 1'b0;
               done_in = 1'b0;
               if (req.operation == OP_CANCEL) begin
                  state_in = S_SCAN;
               end else if (req.operation == OP_NONE || req.quantity == '0) begin
                  out_in = '{K_REJECTED, '0, '0, '0, '0, 1'b1};
                  ovalid_in = 1'b1;
               end else begin
                  next_id_in = next_id_ff + 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (op_ff == OP_CANCEL) begin
               // Lowest-index valid slot with the requested id.
               if (valid_ff[cur] && oid_ff[cur] == cid_ff) begin
                  valid_in[cur] = 1'b0;
                  out_in = '{K_CANCELLED, cid_ff, cp, '0, qty_ff[cur], 1'b1};
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (idx_ff == CW'(MAX_RESTING - 1)) begin
                  out_in = '{K_UNKNOWN, cid_ff, '0, '0, '0, 1'b1};
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               if (cand && better) begin
                  found_in = 1'b1;
                  best_in = cur;
                  bprice_in = cp;
                  bage_in = cage;
               end
               if (idx_ff == CW'(MAX_RESTING - 1)) begin
                  state_in = S_FILL;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FILL: begin
            // Apply one fill to the best slot, or finish the match phase.
            if (!found_ff) begin
               idx_in = '0;
               state_in = S_FREE;
            end else begin
               fill_in = (qty_ff[best_ff] < rem_ff) ? qty_ff[best_ff] : rem_ff;
               wr_en = 1'b1;
               wr_qty = qty_ff[best_ff] - fill_in;
               if (wr_qty == '0) begin
                  valid_in[best_ff] = 1'b0;
               end
               rem_in = rem_ff - fill_in;
               nfill_in = nfill_ff + 1'b1;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!ovalid_ff || rsp.ready) begin
               out_in = '{K_FILL, oid_ff[best_ff], bprice_ff, fill_ff, rem_ff, 1'b0};
               ovalid_in = 1'b1;
               idx_in = '0;
               found_in = 1'b0;
               if (rem_ff == '0) begin
                  done_in = 1'b1;
                  state_in = S_FREE;
               end else if (nfill_ff == CW'(MAX_RESTING)) begin
                  state_in = S_FREE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_FREE: begin
            if (!ovalid_ff || rsp.ready) begin
               if (done_ff) begin
                  out_in = '{K_FULL_FILL, id_ff, lim_ff, '0, '0, 1'b1};
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (!valid_ff[cur]) begin
                  wr_full = 1'b1;
                  wr_idx = cur;
                  valid_in[cur] = 1'b1;
                  out_in = '{K_RESTED, id_ff, lim_ff, '0, rem_ff, 1'b1};
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else if (idx_ff == CW'(MAX_RESTING - 1)) begin
                  out_in = '{K_BOOK_FULL, id_ff, lim_ff, '0, rem_ff, 1'b1};
                  ovalid_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         next_id_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         next_id_ff <= next_id_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // Payload registers and slot storage.
   always_ff @(posedge clock) begin
      op_ff <= op_in;
      rem_ff <= rem_in;
      lim_ff <= lim_in;
      cid_ff <= cid_in;
      id_ff <= id_in;
      idx_ff <= idx_in;
      nfill_ff <= nfill_in;
      found_ff <= found_in;
      best_ff <= best_in;
      bprice_ff <= bprice_in;
      bage_ff <= bage_in;
      fill_ff <= fill_in;
      done_ff <= done_in;
      out_ff <= out_in;
      if (wr_en) begin
         qty_ff[wr_idx] <= wr_qty;
      end
      if (wr_full) begin
         qty_ff[wr_idx] <= rem_ff;
         sell_ff[wr_idx] <= is_sell;
         price_ff[wr_idx] <= lim_ff;
         oid_ff[wr_idx] <= id_ff;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/lom_checker.sv =====
// Port-level checker for the limit order matching core, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module lom_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [2:0] rsp_kind,
   input wire logic rsp_last
);
   import lom_pkg::*;

   // A held response word stays valid until taken.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // Fills are never the final word; every other kind is.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind != K_FILL))) else $error("last flag wrong");

   // The core takes no request while a response is pending.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while busy");

   // An accepted request drops ready on the next cycle.
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("ready after accept");
endmodule

bind limit_order_matching_core lom_checker u_lom_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req.valid),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_kind(rsp.kind),
   .rsp_last(rsp.last)
);
`default_nettype wire

// ===== verif/lom_tb_if.sv =====
// Testbench note: the channel interfaces come from the RTL file lom_if.sv.
`timescale 1ns / 1ps
package lom_tb_pkg;
   import lom_pkg::*;

   // One expected response word.
   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [IdW-1:0] order_id;
      logic [PriceW-1:0] trade_price;
      logic [QtyW-1:0] trade_quantity;
      logic [QtyW-1:0] remaining;
      logic last;
   } book_result_type;
endpackage

// ===== verif/tb_limit_order_matching_core.sv =====
// Self-checking testbench for the limit order matching core.
`timescale 1ns / 1ps
module tb_limit_order_matching_core;
   import lom_pkg::*;
   import lom_tb_pkg::*;

   localparam int unsigned Slots = 32;
   localparam int unsigned ScanCycles = Slots + 2;
   localparam int unsigned WatchLimit = 34 * (ScanCycles + 1) + 40 * 13 + 2000;

   logic clock;
   logic reset;
   lom_req_if req ();
   lom_rsp_if rsp ();

   limit_order_matching_core #(.MAX_RESTING(Slots)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // Book shadow kept by the testbench.
   logic book_valid [Slots];
   logic book_is_sell [Slots];
   logic [PriceW-1:0] book_price [Slots];
   logic [QtyW-1:0] book_qty [Slots];
   logic [IdW-1:0] book_id [Slots];
   logic [IdW-1:0] id_counter;

   book_result_type pending_results [$];
   int errors = 0;
   int idle_cycles;
   int hold_off;
   int rsp_wait;
   bit hold_arm;
   bit hold_used;
   bit rsp_random;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Best crossing resting order on one side, or -1.
   function automatic int best_resting(logic want_sell, logic [PriceW-1:0] limit,
                                       logic [IdW-1:0] now);
      int best;
      logic [IdW-1:0] age_i;
      logic [IdW-1:0] age_b;
      best = -1;
      for (int i = 0; i < Slots; i++) begin
         if (!book_valid[i] || book_is_sell[i] != want_sell) continue;
         if (want_sell ? (book_price[i] > limit) : (book_price[i] < limit)) continue;
         if (best < 0) begin
            best = i;
         end else if (book_price[i] != book_price[best]) begin
            if (want_sell ? (book_price[i] < book_price[best])
                          : (book_price[i] > book_price[best])) best = i;
         end else begin
            age_i = now - book_id[i];
            age_b = now - book_id[best];
            if (age_i > age_b) best = i;
         end
      end
      return best;
   endfunction

   function automatic void push_result(kind_type kind, logic [IdW-1:0] id,
                                       logic [PriceW-1:0] price, logic [QtyW-1:0] qty,
                                       logic [QtyW-1:0] rem, logic last);
      book_result_type r;
      r.kind = kind;
      r.order_id = id;
      r.trade_price = price;
      r.trade_quantity = qty;
      r.remaining = rem;
      r.last = last;
      pending_results.push_back(r);
   endfunction

   // Work out the response words of one accepted request.
   function automatic void match_order(op_type op, logic [QtyW-1:0] qty,
                                       logic [PriceW-1:0] limit, logic [IdW-1:0] cid);
      logic is_sell;
      logic [IdW-1:0] id;
      logic [QtyW-1:0] rem;
      logic [QtyW-1:0] fill;
      int fills;
      int b;
      int free_slot;
      if (op == OP_CANCEL) begin
         for (int i = 0; i < Slots; i++) begin
            if (book_valid[i] && book_id[i] == cid) begin
               book_valid[i] = 1'b0;
               push_result(K_CANCELLED, cid, book_price[i], '0, book_qty[i], 1'b1);
               return;
            end
         end
         push_result(K_UNKNOWN, cid, '0, '0, '0, 1'b1);
         return;
      end
      if (op == OP_NONE || qty == '0) begin
         push_result(K_REJECTED, '0, '0, '0, '0, 1'b1);
         return;
      end
      is_sell = (op == OP_SELL);
      id = id_counter;
      id_counter = id_counter + 1'b1;
      rem = qty;
      fills = 0;
      while (rem != '0 && fills < Slots) begin
         b = best_resting(!is_sell, limit, id);
         if (b < 0) break;
         fill = (book_qty[b] < rem) ? book_qty[b] : rem;
         book_qty[b] = book_qty[b] - fill;
         rem = rem - fill;
         if (book_qty[b] == '0) book_valid[b] = 1'b0;
         push_result(K_FILL, book_id[b], book_price[b], fill, rem, 1'b0);
         fills++;
      end
      if (rem == '0) begin
         push_result(K_FULL_FILL, id, limit, '0, '0, 1'b1);
         return;
      end
      free_slot = -1;
      for (int i = 0; i < Slots; i++) begin
         if (!book_valid[i]) begin
            free_slot = i;
            break;
         end
      end
      if (free_slot < 0) begin
         push_result(K_BOOK_FULL, id, limit, '0, rem, 1'b1);
         return;
      end
      book_valid[free_slot] = 1'b1;
      book_is_sell[free_slot] = is_sell;
      book_price[free_slot] = limit;
      book_qty[free_slot] = rem;
      book_id[free_slot] = id;
      push_result(K_RESTED, id, limit, '0, rem, 1'b1);
   endfunction

   // Send one request word after a random gap and predict its responses.
   // Valid stays high after the accept until the next call or a drain drops it.
   task automatic send_order(op_type op, logic [QtyW-1:0] qty,
                             logic [PriceW-1:0] limit, logic [IdW-1:0] cid);
      int gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.operation <= op;
      req.quantity <= qty;
      req.limit_price <= limit;
      req.cancel_id <= cid;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      match_order(op, qty, limit, cid);
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4 * ScanCycles) @(posedge clock);
   endtask

   // Id of a resting order, or a random id when the book is empty.
   function automatic logic [IdW-1:0] resting_id();
      int picks [$];
      for (int i = 0; i < Slots; i++) if (book_valid[i]) picks.push_back(i);
      if (picks.size() == 0) return $urandom();
      return book_id[picks[$urandom_range(0, picks.size() - 1)]];
   endfunction

   // Response side: a drawn wait before each word, or a long hold-off once armed.
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_off <= 0;
         hold_used <= 1'b0;
         rsp_wait <= 0;
      end else if (hold_arm && !hold_used) begin
         hold_used <= 1'b1;
         hold_off <= 400;
         rsp.ready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp.ready <= 1'b0;
      end else if (rsp.valid && rsp.ready) begin
         draw = rsp_random ? $urandom_range(0, 12) : 0;
         rsp_wait <= draw;
         rsp.ready <= (draw == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp.ready <= (rsp_wait == 1);
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // Compare each accepted response word with the oldest expectation.
   always @(posedge clock) begin
      book_result_type want;
      book_result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.kind = rsp.kind;
         got.order_id = rsp.order_id;
         got.trade_price = rsp.trade_price;
         got.trade_quantity = rsp.trade_quantity;
         got.remaining = rsp.remaining;
         got.last = rsp.last;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response word %h", $time, got);
            errors++;
         end else begin
            want = pending_results[0];
            pending_results.delete(0);
            if (want.kind != got.kind)
               $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            if (want.order_id != got.order_id)
               $display("%0t: order_id expected %0h actual %0h", $time, want.order_id,
                        got.order_id);
            if (want.trade_price != got.trade_price)
               $display("%0t: trade_price expected %0h actual %0h", $time,
                        want.trade_price, got.trade_price);
            if (want.trade_quantity != got.trade_quantity)
               $display("%0t: trade_quantity expected %0h actual %0h", $time,
                        want.trade_quantity, got.trade_quantity);
            if (want.remaining != got.remaining)
               $display("%0t: remaining expected %0h actual %0h", $time, want.remaining,
                        got.remaining);
            if (want.last != got.last)
               $display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
            if (want != got) errors++;
         end
      end
   end

   // Watchdog on cycles with no accepted word on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchLimit) begin
            $display("limit_order_matching_core regression: fail");
            $finish;
         end
      end
   end

   // Edge values, every operation and the special cases.
   task automatic test_directed();
      send_order(OP_CANCEL, '0, '0, 32'hFFFF_FFFF);
      send_order(OP_BUY, '0, 32'd100, '0);
      send_order(OP_NONE, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(OP_BUY, 24'd10, 32'd100, '0);
      send_order(OP_BUY, 24'd5, 32'd100, '0);
      send_order(OP_BUY, 24'd7, 32'd120, '0);
      send_order(OP_SELL, 24'd3, 32'd90, '0);
      send_order(OP_SELL, 24'd20, 32'd100, '0);
      send_order(OP_SELL, 24'hFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_order(OP_BUY, 24'hFF_FFFF, '0, '0);
      send_order(OP_BUY, 24'd1, 32'hFFFF_FFFF, '0);
      send_order(OP_SELL, 24'd4, '0, '0);
      send_order(OP_CANCEL, '0, '0, 32'd7);
      send_order(OP_CANCEL, '0, '0, 32'd7);
      send_order(OP_CANCEL, '0, '0, resting_id());
      wait_drained();
   endtask

   // Fill the book, overflow it, then sweep it with one large order; once for each side.
   task automatic test_book_full();
      for (int i = 0; i < Slots + 2; i++)
         send_order(OP_SELL, QtyW'($urandom_range(1, 3)), 32'd1000 + $urandom_range(0, 3),
                    '0);
      send_order(OP_BUY, 24'hFF_FFFF, 32'hFFFF_FFFF, $urandom());
      wait_drained();
      for (int i = 0; i < Slots; i++)
         send_order(OP_BUY, QtyW'($urandom_range(1, 2)), 32'd50, '0);
      send_order(OP_SELL, 24'd1, 32'd60, '0);
      send_order(OP_SELL, 24'hFF_FFFF, '0, '0);
      wait_drained();
   endtask

   // Random traffic around a fixed mid price of 5000, mostly valid orders.
   task automatic test_random(int count);
      int r;
      logic [PriceW-1:0] px;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         px = 32'd5000 + $urandom_range(0, 20) - 10;
         if (r < 40) send_order(OP_BUY, QtyW'($urandom_range(1, 40)), px, $urandom());
         else if (r < 80) send_order(OP_SELL, QtyW'($urandom_range(1, 40)), px, $urandom());
         else if (r < 90) send_order(OP_CANCEL, QtyW'($urandom()), $urandom(), resting_id());
         else if (r < 93) send_order(OP_CANCEL, '0, '0, $urandom());
         else if (r < 96) send_order(op_type'($urandom_range(0, 1)), QtyW'($urandom()),
                                     $urandom(), $urandom());
         else if (r < 98) send_order(op_type'($urandom_range(0, 1)), '0, $urandom(), '0);
         else send_order(OP_NONE, QtyW'($urandom()), $urandom(), $urandom());
      end
   endtask

   // Long response stall while requests keep coming, then a full drain, then traffic with no response waits.
   task automatic test_backpressure();
      hold_arm = 1'b1;
      test_random(20);
      wait_drained();
      rsp_random = 1'b0;
      test_random(30);
      rsp_random = 1'b1;
      wait_drained();
   endtask

   initial begin
      hold_arm = 1'b0;
      rsp_random = 1'b1;
      id_counter = '0;
      for (int i = 0; i < Slots; i++) begin
         book_valid[i] = 1'b0;
         book_is_sell[i] = 1'b0;
         book_price[i] = '0;
         book_qty[i] = '0;
         book_id[i] = '0;
      end
      reset <= 1'b1;
      req.valid <= 1'b0;
      req.operation <= OP_BUY;
      req.quantity <= '0;
      req.limit_price <= '0;
      req.cancel_id <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_book_full();
      test_backpressure();
      test_random(140);
      wait_drained();
      if (errors == 0) begin
         $display("limit_order_matching_core regression: pass");
      end else begin
         $display("limit_order_matching_core regression: fail");
      end
      $finish;
   end
endmodule
